// ===== sv/kmp_substring_search_assert.svh =====
// Assertion macros for the substring search block.
`ifndef KMP_SUBSTRING_SEARCH_ASSERT_SVH
`define KMP_SUBSTRING_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
`define KMP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed in kmp_substring_search");
`define KMP_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed in kmp_substring_search");
`else
`define KMP_ASSERT(label, prop)
`define KMP_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== sv/kmp_pkg.sv =====
package kmp_pkg;

    localparam int MAX_PATTERN     = 32;
    localparam int TEXT_INDEX_BITS = 16;
    localparam int POS_W           = 16;
    localparam int PTR_W           = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W           = $clog2(MAX_PATTERN + 1);
    localparam int CALC_BASE_W     = (TEXT_INDEX_BITS > POS_W) ? TEXT_INDEX_BITS : POS_W;
    localparam int CALC_W          = ((CALC_BASE_W > LEN_W) ? CALC_BASE_W : LEN_W) + 1;

    typedef logic [PTR_W-1:0]           ptr_t;
    typedef logic [LEN_W-1:0]           len_t;
    typedef logic [TEXT_INDEX_BITS-1:0] tidx_t;
    typedef logic [CALC_W-1:0]          calc_t;

    typedef enum logic
    {
        CMD_PATTERN = 1'b0,
        CMD_TEXT    = 1'b1
    } cmd_t;

    typedef enum logic
    {
        ST_IDLE = 1'b0,
        ST_STEP = 1'b1
    } state_t;

    typedef struct packed
    {
        cmd_t       cmd;
        logic [7:0] ch;
        logic       first;
        logic       last;
    } item_t;

    typedef struct packed
    {
        logic             found;
        logic [POS_W-1:0] position;
    } result_t;

endpackage

// ===== sv/kmp_substring_search.sv =====
// Streaming Knuth-Morris-Pratt search. Pattern bytes (cmd pattern) build the stored pattern and
// its failure table one byte at a time; text bytes (cmd text) advance the matcher, and the first
// full match gives one result with found set and the zero-based start position, while a byte
// marked last that ends the text without a match gives found clear; with an empty pattern the
// first text byte gives found at position zero. An accepted item then needs one character
// compare plus one for each failure-table fallback for that byte; pattern bytes that start or
// overflow the pattern, and text bytes after a result, need none. The compare loop reads the
// pattern and failure memories through registered read ports, and no new item is taken until
// the last one is through. A result waiting in the output register does not block the next
// transaction unless that transaction produces a result of its own.
`include "kmp_substring_search_assert.svh"

module kmp_substring_search
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  kmp_pkg::item_t   item,
    output logic            result_valid,
    input  logic            result_stall,
    output kmp_pkg::result_t result
);

    kmp_pkg::state_t  state_reg, state_next;
    kmp_pkg::item_t   cur_reg, cur_next;
    kmp_pkg::ptr_t    k_reg, k_next;
    kmp_pkg::len_t    len_reg, len_next;
    kmp_pkg::ptr_t    bpc_reg, bpc_next;
    kmp_pkg::len_t    mc_reg, mc_next;
    kmp_pkg::tidx_t   tidx_reg, tidx_next;
    logic             done_reg, done_next;
    kmp_pkg::result_t result_reg, result_next;
    logic             result_valid_reg, result_valid_next;

    logic [7:0]    pat_mem [kmp_pkg::MAX_PATTERN];
    kmp_pkg::ptr_t fail_mem [kmp_pkg::MAX_PATTERN];
    logic [7:0]    pat_rdata_reg;
    kmp_pkg::ptr_t fail_rdata_reg;

    logic          pat_we;
    kmp_pkg::ptr_t pat_waddr;
    logic [7:0]    pat_wdata;
    logic          fail_we;
    kmp_pkg::ptr_t fail_waddr;
    kmp_pkg::ptr_t fail_wdata;
    logic          rd_en;
    kmp_pkg::ptr_t rd_addr;
    kmp_pkg::ptr_t fail_raddr;

    logic          accept;
    logic          out_free;
    logic          miss;
    kmp_pkg::len_t len_eff;
    kmp_pkg::ptr_t bpc_eff;
    kmp_pkg::ptr_t k_start;
    kmp_pkg::len_t k_final;
    logic          full_match;
    kmp_pkg::calc_t pos_calc;

    assign item_stall   = (state_reg != kmp_pkg::ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign fail_raddr = rd_addr - kmp_pkg::ptr_t'(1);
    assign miss       = (pat_rdata_reg != cur_reg.ch);
    assign k_final    = kmp_pkg::len_t'(k_reg) + kmp_pkg::len_t'(!miss);
    assign full_match = (k_final >= len_reg);
    assign pos_calc   = kmp_pkg::calc_t'(tidx_reg) + kmp_pkg::calc_t'(1)
                        - kmp_pkg::calc_t'(len_reg);
    assign len_eff    = item.first ? '0 : len_reg;
    assign bpc_eff    = item.first ? '0 : bpc_reg;
    assign k_start    = item.first ? '0 : mc_reg[kmp_pkg::PTR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pat_mem[pat_waddr] <= pat_wdata;
        end
        if (fail_we)
        begin
            fail_mem[fail_waddr] <= fail_wdata;
        end
        if (rd_en)
        begin
            pat_rdata_reg  <= pat_mem[rd_addr];
            fail_rdata_reg <= fail_mem[fail_raddr];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cur_next          = cur_reg;
        k_next            = k_reg;
        len_next          = len_reg;
        bpc_next          = bpc_reg;
        mc_next           = mc_reg;
        tidx_next         = tidx_reg;
        done_next         = done_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        pat_we            = 1'b0;
        pat_waddr         = len_eff[kmp_pkg::PTR_W-1:0];
        pat_wdata         = item.ch;
        fail_we           = 1'b0;
        fail_waddr        = len_reg[kmp_pkg::PTR_W-1:0];
        fail_wdata        = k_final[kmp_pkg::PTR_W-1:0];
        rd_en             = 1'b0;
        rd_addr           = k_reg;

        unique case (state_reg)
            kmp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cur_next = item;
                    if (item.cmd == kmp_pkg::CMD_PATTERN)
                    begin
                        mc_next   = '0;
                        tidx_next = '0;
                        done_next = 1'b0;
                        len_next  = len_eff;
                        bpc_next  = bpc_eff;
                        if (len_eff < kmp_pkg::len_t'(kmp_pkg::MAX_PATTERN))
                        begin
                            pat_we = 1'b1;
                            if (len_eff == '0)
                            begin
                                fail_we    = 1'b1;
                                fail_waddr = '0;
                                fail_wdata = '0;
                                bpc_next   = '0;
                                len_next   = kmp_pkg::len_t'(1);
                            end
                            else
                            begin
                                k_next     = bpc_eff;
                                rd_en      = 1'b1;
                                rd_addr    = bpc_eff;
                                state_next = kmp_pkg::ST_STEP;
                            end
                        end
                    end
                    else
                    begin
                        if (item.first)
                        begin
                            mc_next   = '0;
                            tidx_next = '0;
                            done_next = 1'b0;
                        end
                        if (item.first || !done_reg)
                        begin
                            k_next     = k_start;
                            rd_en      = 1'b1;
                            rd_addr    = k_start;
                            state_next = kmp_pkg::ST_STEP;
                        end
                    end
                end
            end

            kmp_pkg::ST_STEP:
            begin
                if (cur_reg.cmd == kmp_pkg::CMD_TEXT && len_reg == '0)
                begin
                    if (out_free)
                    begin
                        result_next.found    = 1'b1;
                        result_next.position = '0;
                        result_valid_next    = 1'b1;
                        done_next            = 1'b1;
                        state_next           = kmp_pkg::ST_IDLE;
                    end
                end
                else if (k_reg != '0 && miss)
                begin
                    k_next  = fail_rdata_reg;
                    rd_en   = 1'b1;
                    rd_addr = fail_rdata_reg;
                end
                else if (cur_reg.cmd == kmp_pkg::CMD_PATTERN)
                begin
                    fail_we    = 1'b1;
                    bpc_next   = k_final[kmp_pkg::PTR_W-1:0];
                    len_next   = len_reg + kmp_pkg::len_t'(1);
                    state_next = kmp_pkg::ST_IDLE;
                end
                else if (out_free || !(full_match || cur_reg.last))
                begin
                    mc_next = k_final;
                    if (tidx_reg != '1)
                    begin
                        tidx_next = tidx_reg + kmp_pkg::tidx_t'(1);
                    end
                    if (full_match)
                    begin
                        result_next.found    = 1'b1;
                        result_next.position = pos_calc[kmp_pkg::POS_W-1:0];
                        result_valid_next    = 1'b1;
                        done_next            = 1'b1;
                    end
                    else if (cur_reg.last)
                    begin
                        result_next.found    = 1'b0;
                        result_next.position = '0;
                        result_valid_next    = 1'b1;
                        done_next            = 1'b1;
                    end
                    state_next = kmp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = kmp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= kmp_pkg::ST_IDLE;
            len_reg          <= '0;
            bpc_reg          <= '0;
            mc_reg           <= '0;
            tidx_reg         <= '0;
            done_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            len_reg          <= len_next;
            bpc_reg          <= bpc_next;
            mc_reg           <= mc_next;
            tidx_reg         <= tidx_next;
            done_reg         <= done_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        k_reg      <= k_next;
        result_reg <= result_next;
    end

    `KMP_ASSERT_ALWAYS(a_len_bound,
        !rst_n || (len_reg <= kmp_pkg::len_t'(kmp_pkg::MAX_PATTERN)))
    `KMP_ASSERT(a_match_bound, mc_reg <= len_reg)
    `KMP_ASSERT(a_k_in_pattern,
        (state_reg == kmp_pkg::ST_STEP && len_reg != '0)
        |-> (kmp_pkg::len_t'(k_reg) < len_reg))
    `KMP_ASSERT(a_done_clear,
        $fell(done_reg) |-> $past(item_valid && !item_stall
                                  && (item.first || item.cmd == kmp_pkg::CMD_PATTERN)))

endmodule

// ===== dv/kmp_substring_search_tb.sv =====
`timescale 1ns / 100ps

module kmp_substring_search_tb;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_stall;
    kmp_pkg::item_t   item;
    logic             result_valid;
    logic             result_stall;
    kmp_pkg::result_t result;

    int send_idle_pct;
    int rx_stall_pct;

    logic [7:0]     stored_pattern [kmp_pkg::MAX_PATTERN];
    kmp_pkg::len_t  stored_failure [kmp_pkg::MAX_PATTERN];
    kmp_pkg::len_t  stored_length;
    kmp_pkg::len_t  build_prefix;
    kmp_pkg::len_t  matched_length;
    kmp_pkg::tidx_t text_pos;
    bit             search_over;

    kmp_pkg::result_t expected_results [$];
    kmp_pkg::result_t head_result;

    int n_items;
    int n_checked;
    int n_found;
    int n_missed;
    int n_errors;

    kmp_substring_search dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("kmp_substring_search_tb: done, errors");
        $finish;
    end

    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            result_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    function automatic kmp_pkg::item_t make_item(kmp_pkg::cmd_t c, logic [7:0] ch,
                                                 logic f, logic l);
        kmp_pkg::item_t t;
        t.cmd   = c;
        t.ch    = ch;
        t.first = f;
        t.last  = l;
        return t;
    endfunction

    // Updates the expected search state and queues any result the transaction produces.
    function automatic void predict_search_step(kmp_pkg::item_t t);
        kmp_pkg::len_t    k;
        kmp_pkg::result_t r;
        int               pos;
        if (t.cmd == kmp_pkg::CMD_PATTERN)
        begin
            if (t.first)
            begin
                stored_length = '0;
                build_prefix  = '0;
            end
            matched_length = '0;
            text_pos       = '0;
            search_over    = 1'b0;
            if (stored_length >= kmp_pkg::MAX_PATTERN)
                return;
            stored_pattern[kmp_pkg::ptr_t'(stored_length)] = t.ch;
            if (stored_length == 0)
                build_prefix = '0;
            else
            begin
                k = build_prefix;
                while (k > 0 && stored_pattern[kmp_pkg::ptr_t'(k)] != t.ch)
                    k = stored_failure[kmp_pkg::ptr_t'(k - 1'b1)];
                if (stored_pattern[kmp_pkg::ptr_t'(k)] == t.ch)
                    k = k + 1'b1;
                build_prefix = k;
            end
            stored_failure[kmp_pkg::ptr_t'(stored_length)] = build_prefix;
            stored_length = stored_length + 1'b1;
            return;
        end
        if (t.first)
        begin
            matched_length = '0;
            text_pos       = '0;
            search_over    = 1'b0;
        end
        if (search_over)
            return;
        if (stored_length == 0)
        begin
            r.found    = 1'b1;
            r.position = '0;
            expected_results.push_back(r);
            search_over = 1'b1;
            return;
        end
        k = matched_length;
        while (k > 0 && stored_pattern[kmp_pkg::ptr_t'(k)] != t.ch)
            k = stored_failure[kmp_pkg::ptr_t'(k - 1'b1)];
        if (k < stored_length && stored_pattern[kmp_pkg::ptr_t'(k)] == t.ch)
            k = k + 1'b1;
        matched_length = k;
        if (matched_length >= stored_length)
        begin
            pos        = int'(text_pos) + 1 - int'(stored_length);
            r.found    = 1'b1;
            r.position = pos[kmp_pkg::POS_W-1:0];
            expected_results.push_back(r);
            search_over = 1'b1;
        end
        else if (t.last)
        begin
            r.found    = 1'b0;
            r.position = '0;
            expected_results.push_back(r);
            search_over = 1'b1;
        end
        if (text_pos != '1)
            text_pos = text_pos + 1'b1;
    endfunction

    // Hold the transaction until the block takes it.
    task automatic send_item(input kmp_pkg::item_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item       <= t;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        predict_search_step(t);
        n_items++;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, found %0b position %0d",
                         $time, result.found, result.position);
                n_errors++;
            end
            else
            begin
                head_result = expected_results.pop_front();
                n_checked++;
                if (head_result.found)
                    n_found++;
                else
                    n_missed++;
                if (result.found !== head_result.found)
                begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, head_result.found, result.found);
                    n_errors++;
                end
                if (result.position !== head_result.position)
                begin
                    $display("%0t: position expected %0d actual %0d",
                             $time, head_result.position, result.position);
                    n_errors++;
                end
            end
        end
    end

    task automatic test_empty_pattern();
        send_item(make_item(kmp_pkg::CMD_TEXT, 8'h41, 1'b1, 1'b0));
        send_item(make_item(kmp_pkg::CMD_TEXT, 8'h42, 1'b0, 1'b0));
        send_item(make_item(kmp_pkg::CMD_TEXT, 8'hFF, 1'b1, 1'b1));
    endtask

    task automatic test_directed_search();
        send_item(make_item(kmp_pkg::CMD_PATTERN, 8'h00, 1'b1, 1'b1));
        send_item(make_item(kmp_pkg::CMD_PATTERN, 8'hFF, 1'b0, 1'b0));
        send_item(make_item(kmp_pkg::CMD_PATTERN, 8'h00, 1'b0, 1'b1));
        send_item(make_item(kmp_pkg::CMD_TEXT, 8'h00, 1'b1, 1'b0));
        send_item(make_item(kmp_pkg::CMD_TEXT, 8'hFF, 1'b0, 1'b0));
        send_item(make_item(kmp_pkg::CMD_TEXT, 8'hFF, 1'b0, 1'b0));
        send_item(make_item(kmp_pkg::CMD_TEXT, 8'h00, 1'b0, 1'b0));
        send_item(make_item(kmp_pkg::CMD_TEXT, 8'hFF, 1'b0, 1'b0));
        send_item(make_item(kmp_pkg::CMD_TEXT, 8'h00, 1'b0, 1'b0));
        send_item(make_item(kmp_pkg::CMD_TEXT, 8'h00, 1'b0, 1'b1));
        send_item(make_item(kmp_pkg::CMD_TEXT, 8'h00, 1'b1, 1'b1));
        send_item(make_item(kmp_pkg::CMD_TEXT, 8'h00, 1'b1, 1'b0));
        send_item(make_item(kmp_pkg::CMD_PATTERN, 8'hFF, 1'b0, 1'b1));
        send_item(make_item(kmp_pkg::CMD_TEXT, 8'h00, 1'b0, 1'b0));
        send_item(make_item(kmp_pkg::CMD_TEXT, 8'hFF, 1'b0, 1'b0));
        send_item(make_item(kmp_pkg::CMD_TEXT, 8'h00, 1'b0, 1'b0));
        send_item(make_item(kmp_pkg::CMD_TEXT, 8'hFF, 1'b0, 1'b1));
        send_item(make_item(kmp_pkg::CMD_TEXT, 8'h5A, 1'b1, 1'b1));
        send_item(make_item(kmp_pkg::CMD_TEXT, 8'hA5, 1'b1, 1'b0));
        send_item(make_item(kmp_pkg::CMD_TEXT, 8'hFF, 1'b0, 1'b1));
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_target);
        logic [7:0] alpha [3];
        logic [7:0] pat_q [$];
        logic [7:0] txt_q [$];
        int         start_items;
        int         n_letters;
        int         plen;
        int         i;
        logic [7:0] c;
        logic       f;
        logic       l;
        send_idle_pct = idle_pct;
        rx_stall_pct  = stall_pct;
        start_items   = n_items;
        while (n_items - start_items < n_target)
        begin
            if (pat_q.size() == 0 || $urandom_range(99) < 80)
            begin
                foreach (alpha[j])
                    alpha[j] = 8'($urandom);
                n_letters = ($urandom_range(3) == 0) ? 3 : 2;
                plen = ($urandom_range(9) == 0) ? $urandom_range(20, 36) : $urandom_range(1, 6);
                pat_q.delete();
                for (i = 0; i < plen; i++)
                    pat_q.push_back(alpha[$urandom_range(n_letters - 1)]);
                for (i = 0; i < plen; i++)
                    send_item(make_item(kmp_pkg::CMD_PATTERN, pat_q[i], i == 0, 1'($urandom)));
            end
            txt_q.delete();
            for (i = $urandom_range(0, 12); i > 0; i--)
                txt_q.push_back(alpha[$urandom_range(n_letters - 1)]);
            if ($urandom_range(99) < 60)
                foreach (pat_q[j])
                    txt_q.push_back(pat_q[j]);
            for (i = $urandom_range(0, 12); i > 0; i--)
                txt_q.push_back(alpha[$urandom_range(n_letters - 1)]);
            if (txt_q.size() == 0)
                txt_q.push_back(alpha[0]);
            for (i = 0; i < txt_q.size(); i++)
            begin
                c = ($urandom_range(9) == 0) ? 8'($urandom) : txt_q[i];
                f = (i == 0) ? ($urandom_range(19) != 0) : ($urandom_range(39) == 0);
                l = (i == txt_q.size() - 1) ? ($urandom_range(9) != 0)
                                            : ($urandom_range(39) == 0);
                if ($urandom_range(49) == 0)
                begin
                    pat_q.push_back(c);
                    send_item(make_item(kmp_pkg::CMD_PATTERN, c, 1'b0, l));
                end
                else
                    send_item(make_item(kmp_pkg::CMD_TEXT, c, f, l));
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        send_idle_pct  = 0;
        rx_stall_pct   = 0;
        stored_length  = '0;
        build_prefix   = '0;
        matched_length = '0;
        text_pos       = '0;
        search_over    = 1'b0;
        n_items        = 0;
        n_checked      = 0;
        n_found        = 0;
        n_missed       = 0;
        n_errors       = 0;
        foreach (stored_pattern[j])
        begin
            stored_pattern[j] = '0;
            stored_failure[j] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_pattern();
        test_directed_search();
        test_random_traffic(0, 0, 320);
        test_random_traffic(83, 0, 310);
        test_random_traffic(0, 83, 310);
        test_random_traffic(10, 10, 310);

        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("kmp_substring_search_tb: %0d pattern and text bytes sent to the block,",
                 n_items);
        $display("kmp_substring_search_tb: %0d results checked, %0d matches and %0d misses",
                 n_checked, n_found, n_missed);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("kmp_substring_search_tb: done, clean");
        else
            $display("kmp_substring_search_tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/kmp_pkg.sv
sv/kmp_substring_search.sv
dv/kmp_substring_search_tb.sv
